// ----- src/gasa_pkg.sv -----
package gasa_pkg;

    localparam int KEY_W  = 32;
    localparam int ID_W   = 31;
    localparam int DIM_W  = 12;
    localparam int LEFT_W = 13;
    localparam int TOP_W  = 15;
    localparam int BASE_W = 13;
    localparam int PAD_W  = 8;
    localparam int HGT_W  = 15;
    localparam int PENX_W = 14;
    localparam int PENY_W = 16;
    localparam int CFGI_W = 2;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    // register indexes on the configuration port
    localparam logic [CFGI_W-1:0] CFG_BASE_SIZE  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_PADDING    = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_MAX_HEIGHT = 2'd2;

    localparam logic [BASE_W-1:0] BASE_SIZE_RST  = 13'd32;
    localparam logic [PAD_W-1:0]  PADDING_RST    = 8'd1;
    localparam logic [HGT_W-1:0]  MAX_HEIGHT_RST = 15'd4096;

    typedef enum logic [1:0] {
        RES_PLACED = 2'd0,
        RES_CACHED = 2'd1,
        RES_REUSED = 2'd2,
        RES_FAILED = 2'd3
    } t_res;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEFT_W-1:0] left;
        logic [TOP_W-1:0]  top;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
    } t_entry;

    typedef struct packed {
        logic key_hit;
        logic oth_fit;
    } t_cmp;

    // starting atlas width picked by the font base size
    function automatic logic [LEFT_W-1:0] base_width(input logic [BASE_W-1:0] bs);
        logic [LEFT_W-1:0] w;
        if (bs <= 13'd16) begin
            w = 13'd512;
        end else if (bs <= 13'd32) begin
            w = 13'd768;
        end else if (bs <= 13'd48) begin
            w = 13'd1024;
        end else if (bs <= 13'd64) begin
            w = 13'd1536;
        end else if (bs <= 13'd256) begin
            w = 13'd2048;
        end else begin
            w = 13'd4096;
        end
        return w;
    endfunction

    function automatic logic [HGT_W-1:0] base_height(input logic [BASE_W-1:0] bs);
        return (bs <= 13'd256) ? 15'd256 : 15'd512;
    endfunction

endpackage

// ----- src/gasa_entry_mem.sv -----
module gasa_entry_mem
    import gasa_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/gasa_key_cmp.sv -----
module gasa_key_cmp
    import gasa_pkg::*;
(
    input  t_entry           i_entry,
    input  logic [KEY_W-1:0] i_key,
    input  logic [DIM_W-1:0] i_gw,
    input  logic [DIM_W-1:0] i_gh,
    output t_cmp             o_cmp
);

    logic [KEY_W-1:0] w_other;

    // same glyph, opposite reading direction
    assign w_other = {~i_key[KEY_W-1], i_key[KEY_W-2:0]};

    always_comb begin
        o_cmp.key_hit = (i_entry.key == i_key);
        o_cmp.oth_fit = (i_entry.key == w_other) && (i_entry.w == i_gw) && (i_entry.h == i_gh);
    end

endmodule

// ----- src/glyph_atlas_shelf_allocator.sv -----
// Glyph atlas shelf allocator. Each request (glyph id and direction on tdata/tuser) is
// looked up in an entry table by a linear scan through one read port, one entry per cycle.
// The scan stops at a cached glyph or after all COUNT stored entries (up to TABLE_ENTRIES);
// a miss then fails on a full table, reuses a match from the other direction, or goes
// through the pad, wrap, need and grow steps to place the glyph. One request is in flight
// at a time; a result waiting in the output register does not block the next request.
// Status on m_axis_tuser: 0 placed, 1 cached, 2 reused from the other direction, 3 failed.
// The first request fixes the atlas width and starting height from base_size.
module glyph_atlas_shelf_allocator
    import gasa_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFGI_W-1:0]      i_cfg_index,
    input  logic [HGT_W-1:0]       i_cfg_data,
    // requests
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // glyph_id, glyph_width, glyph_height, pad
    input  logic                   s_axis_tuser,   // vertical
    // results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // region_left, region_top, atlas_height, pad
    output logic [1:0]             m_axis_tuser    // status
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_PAD,
        S_WRAP,
        S_NEED,
        S_GROW,
        S_FINISH
    } t_state;

    t_state            r_state;
    logic [BASE_W-1:0] r_base;
    logic [PAD_W-1:0]  r_pad;
    logic [HGT_W-1:0]  r_maxh;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic              r_rd_vld;
    logic [PENX_W-1:0] r_pen_x;
    logic [PENY_W-1:0] r_pen_y;
    logic [DIM_W-1:0]  r_row_h;
    logic [HGT_W-1:0]  r_cur_h;
    logic [LEFT_W-1:0] r_atlas_w;
    logic              r_atlas_rdy;

    logic [KEY_W-1:0]  r_key;
    logic [DIM_W-1:0]  r_gw;
    logic [DIM_W-1:0]  r_gh;
    logic              r_oth_fit;
    logic [LEFT_W-1:0] r_oth_left;
    logic [TOP_W-1:0]  r_oth_top;
    logic [16:0]       r_need;

    t_res              r_res;
    logic [LEFT_W-1:0] r_res_left;
    logic [TOP_W-1:0]  r_res_top;

    logic              r_wr_en;
    logic [AW-1:0]     r_wr_addr;
    t_entry            r_wr_data;

    logic              r_m_valid;
    t_res              r_m_res;
    logic [LEFT_W-1:0] r_m_left;
    logic [TOP_W-1:0]  r_m_top;
    logic [HGT_W-1:0]  r_m_hgt;

    logic              w_rd_en;
    t_entry            w_rd_data;
    t_cmp              w_cmp;
    logic [14:0]       w_span;
    logic              w_wrap;
    logic [16:0]       w_ystep;
    logic [PENY_W-1:0] w_ynext;
    logic [16:0]       w_need;
    logic [17:0]       w_rnd;
    logic [17:0]       w_newh;
    logic              w_grow;
    logic              w_fail;
    logic              w_out_free;

    assign w_rd_en = (r_state == S_SCAN) && (r_idx < r_count);

    gasa_entry_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (r_wr_en),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (r_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    gasa_key_cmp u_cmp (
        .i_entry (w_rd_data),
        .i_key   (r_key),
        .i_gw    (r_gw),
        .i_gh    (r_gh),
        .o_cmp   (w_cmp)
    );

    always_comb begin
        w_span  = 15'(r_pen_x) + 15'(r_gw) + 15'(r_pad);
        w_wrap  = 15'(r_atlas_w) < w_span;
        w_ystep = 17'(r_pen_y) + 17'(r_row_h) + 17'({r_pad, 1'b0});
        // pen_y saturates at the top of its range
        w_ynext = w_ystep[16] ? {PENY_W{1'b1}} : w_ystep[PENY_W-1:0];
        w_need  = 17'(r_pen_y) + 17'(r_gh) + 17'(r_pad);
        // round up to a multiple of 256
        w_rnd   = 18'(r_need) + 18'd255;
        w_newh  = {w_rnd[17:8], 8'd0};
        w_grow  = 17'(r_cur_h) < r_need;
        w_fail  = w_grow && (18'(r_maxh) < w_newh);
        w_out_free = !r_m_valid || m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= BASE_SIZE_RST;
            r_pad       <= PADDING_RST;
            r_maxh      <= MAX_HEIGHT_RST;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_row_h     <= '0;
            r_cur_h     <= '0;
            r_atlas_w   <= '0;
            r_atlas_rdy <= 1'b0;
            r_wr_en     <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_wr_en <= 1'b0;
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BASE_SIZE:  r_base <= i_cfg_data[BASE_W-1:0];
                    CFG_PADDING:    r_pad  <= i_cfg_data[PAD_W-1:0];
                    CFG_MAX_HEIGHT: r_maxh <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_key     <= {s_axis_tuser, s_axis_tdata[ID_W-1:0]};
                        r_gw      <= s_axis_tdata[ID_W+DIM_W-1:ID_W];
                        r_gh      <= s_axis_tdata[ID_W+2*DIM_W-1:ID_W+DIM_W];
                        r_idx     <= '0;
                        r_rd_vld  <= 1'b0;
                        r_oth_fit <= 1'b0;
                        if (!r_atlas_rdy) begin
                            r_atlas_w   <= base_width(r_base);
                            r_cur_h     <= base_height(r_base);
                            r_atlas_rdy <= 1'b1;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_rd_en) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    r_rd_vld <= w_rd_en;
                    if (r_rd_vld && w_cmp.key_hit) begin
                        r_res      <= RES_CACHED;
                        r_res_left <= w_rd_data.left;
                        r_res_top  <= w_rd_data.top;
                        r_state    <= S_FINISH;
                    end else begin
                        if (r_rd_vld && w_cmp.oth_fit) begin
                            r_oth_fit  <= 1'b1;
                            r_oth_left <= w_rd_data.left;
                            r_oth_top  <= w_rd_data.top;
                        end
                        if (!w_rd_en && !r_rd_vld) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_count >= CW'(TABLE_ENTRIES)) begin
                        r_res      <= RES_FAILED;
                        r_res_left <= '0;
                        r_res_top  <= '0;
                        r_state    <= S_FINISH;
                    end else if (r_oth_fit) begin
                        r_wr_en    <= 1'b1;
                        r_wr_addr  <= r_count[AW-1:0];
                        r_wr_data  <= '{key: r_key, left: r_oth_left, top: r_oth_top,
                                        w: r_gw, h: r_gh};
                        r_count    <= r_count + CW'(1);
                        r_res      <= RES_REUSED;
                        r_res_left <= r_oth_left;
                        r_res_top  <= r_oth_top;
                        r_state    <= S_FINISH;
                    end else begin
                        r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_pen_x <= r_pen_x + PENX_W'(r_pad);
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    // glyph does not fit on this shelf: open a new one
                    if (w_wrap) begin
                        r_pen_x <= PENX_W'(r_pad);
                        r_pen_y <= w_ynext;
                        r_row_h <= '0;
                    end
                    r_state <= S_NEED;
                end
                S_NEED: begin
                    r_need  <= w_need;
                    r_state <= S_GROW;
                end
                S_GROW: begin
                    if (w_fail) begin
                        r_res      <= RES_FAILED;
                        r_res_left <= '0;
                        r_res_top  <= '0;
                    end else begin
                        if (w_grow) begin
                            r_cur_h <= w_newh[HGT_W-1:0];
                        end
                        if (r_gh > r_row_h) begin
                            r_row_h <= r_gh;
                        end
                        r_wr_en    <= 1'b1;
                        r_wr_addr  <= r_count[AW-1:0];
                        r_wr_data  <= '{key: r_key, left: r_pen_x[LEFT_W-1:0],
                                        top: r_pen_y[TOP_W-1:0], w: r_gw, h: r_gh};
                        r_count    <= r_count + CW'(1);
                        r_pen_x    <= r_pen_x + PENX_W'(r_gw) + PENX_W'(r_pad);
                        r_res      <= RES_PLACED;
                        r_res_left <= r_pen_x[LEFT_W-1:0];
                        r_res_top  <= r_pen_y[TOP_W-1:0];
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_res   <= r_res;
                        r_m_left  <= r_res_left;
                        r_m_top   <= r_res_top;
                        r_m_hgt   <= r_cur_h;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res;
    assign m_axis_tdata  = {5'd0, r_m_hgt, r_m_top, r_m_left};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_wr_at_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_en |-> (CW'(r_wr_addr) + CW'(1) == r_count))
        else $error("entry written away from the table tail");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new request taken while one is in flight");

    a_atlas_sized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_atlas_rdy |-> (r_cur_h != '0) && (r_atlas_w != '0))
        else $error("atlas marked ready without a size");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && w_out_free) |=> (m_axis_tvalid && r_state == S_IDLE))
        else $error("finished result not moved to the output register");

endmodule

// ----- bench/glyph_atlas_shelf_allocator_test.sv -----
`timescale 1ns / 1ps

module glyph_atlas_shelf_allocator_test;
    import gasa_pkg::*;

    localparam int          TABLE_ENTRIES = 256;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned LONG_HOLD     = 1500;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned DRAIN_CYCLES  = 300;
    // index past the last register, writes to it must change nothing
    localparam logic [CFGI_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum {MIX_CAPPED, MIX_WIDE, MIX_FILL} t_mix;

    typedef struct {
        t_res              status;
        logic [LEFT_W-1:0] left;
        logic [TOP_W-1:0]  top;
        logic [HGT_W-1:0]  height;
    } t_region;

    class atlas_scoreboard;
        logic [BASE_W-1:0] base_size;
        logic [PAD_W-1:0]  padding;
        logic [HGT_W-1:0]  max_height;
        logic [KEY_W-1:0]  slot_key [TABLE_ENTRIES];
        logic [LEFT_W-1:0] slot_left[TABLE_ENTRIES];
        logic [TOP_W-1:0]  slot_top [TABLE_ENTRIES];
        logic [DIM_W-1:0]  slot_w   [TABLE_ENTRIES];
        logic [DIM_W-1:0]  slot_h   [TABLE_ENTRIES];
        int unsigned       entry_count;
        logic [PENX_W-1:0] pen_x;
        logic [PENY_W-1:0] pen_y;
        logic [DIM_W-1:0]  row_height;
        logic [PENY_W-1:0] cur_height;
        logic [LEFT_W-1:0] atlas_width;
        bit                atlas_ready;
        t_region           expected_regions[$];
        int unsigned       errors;

        function new();
            base_size   = BASE_SIZE_RST;
            padding     = PADDING_RST;
            max_height  = MAX_HEIGHT_RST;
            entry_count = 0;
            pen_x       = '0;
            pen_y       = '0;
            row_height  = '0;
            cur_height  = '0;
            atlas_width = '0;
            atlas_ready = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFGI_W-1:0] index, logic [HGT_W-1:0] data);
            case (index)
                CFG_BASE_SIZE:  base_size  = data[BASE_W-1:0];
                CFG_PADDING:    padding    = data[PAD_W-1:0];
                CFG_MAX_HEIGHT: max_height = data;
                default: ;
            endcase
        endfunction

        function int find_slot(logic [KEY_W-1:0] key);
            for (int i = 0; i < entry_count; i++) begin
                if (slot_key[i] == key) return i;
            end
            return -1;
        endfunction

        function void store_slot(logic [KEY_W-1:0] key, logic [LEFT_W-1:0] left,
                                 logic [TOP_W-1:0] top, logic [DIM_W-1:0] w,
                                 logic [DIM_W-1:0] h);
            if (entry_count < TABLE_ENTRIES) begin
                slot_key[entry_count]  = key;
                slot_left[entry_count] = left;
                slot_top[entry_count]  = top;
                slot_w[entry_count]    = w;
                slot_h[entry_count]    = h;
                entry_count++;
            end
        endfunction

        function void push_region(t_res status, logic [LEFT_W-1:0] left, logic [TOP_W-1:0] top);
            t_region r;
            r.status = status;
            r.left   = left;
            r.top    = top;
            r.height = cur_height[HGT_W-1:0];
            expected_regions.push_back(r);
        endfunction

        // one glyph request through lookup, reuse and shelf placement
        function void note_request(logic [ID_W-1:0] id, logic vert, logic [DIM_W-1:0] w,
                                   logic [DIM_W-1:0] h);
            logic [KEY_W-1:0] key;
            logic [KEY_W-1:0] other;
            int               hit;
            int unsigned      px;
            int unsigned      py;
            int unsigned      need;
            int unsigned      grown;
            key   = {vert, id};
            other = {~vert, id};
            if (!atlas_ready) begin
                if (base_size <= 16) atlas_width = 13'd512;
                else if (base_size <= 32) atlas_width = 13'd768;
                else if (base_size <= 48) atlas_width = 13'd1024;
                else if (base_size <= 64) atlas_width = 13'd1536;
                else if (base_size <= 256) atlas_width = 13'd2048;
                else atlas_width = 13'd4096;
                cur_height  = (base_size <= 256) ? 16'd256 : 16'd512;
                atlas_ready = 1'b1;
            end
            hit = find_slot(key);
            if (hit >= 0) begin
                push_region(RES_CACHED, slot_left[hit], slot_top[hit]);
                return;
            end
            if (entry_count >= TABLE_ENTRIES) begin
                push_region(RES_FAILED, '0, '0);
                return;
            end
            hit = find_slot(other);
            if (hit >= 0 && slot_w[hit] == w && slot_h[hit] == h) begin
                store_slot(key, slot_left[hit], slot_top[hit], w, h);
                push_region(RES_REUSED, slot_left[hit], slot_top[hit]);
                return;
            end
            px = 32'(pen_x) + padding;
            if (32'(atlas_width) < px + w + padding) begin
                px         = 32'(padding);
                py         = 32'(pen_y) + row_height + 2 * padding;
                pen_y      = (py > 32'd65535) ? 16'hFFFF : py[PENY_W-1:0];
                row_height = '0;
            end
            pen_x = px[PENX_W-1:0];
            // pen movement above sticks even when the height check fails
            need = 32'(pen_y) + h + padding;
            if (32'(cur_height) < need) begin
                grown = (need + 255) / 256 * 256;
                if (32'(max_height) < grown) begin
                    push_region(RES_FAILED, '0, '0);
                    return;
                end
                cur_height = grown[PENY_W-1:0];
            end
            if (h > row_height) row_height = h;
            store_slot(key, pen_x[LEFT_W-1:0], pen_y[TOP_W-1:0], w, h);
            push_region(RES_PLACED, pen_x[LEFT_W-1:0], pen_y[TOP_W-1:0]);
            px    = 32'(pen_x) + w + padding;
            pen_x = px[PENX_W-1:0];
        endfunction

        function void check_placement(logic [1:0] status, logic [LEFT_W-1:0] left,
                                      logic [TOP_W-1:0] top, logic [HGT_W-1:0] height);
            t_region want;
            if (expected_regions.size() == 0) begin
                $error("result with no request pending: status %0d left %0d top %0d height %0d",
                       status, left, top, height);
                errors++;
                return;
            end
            want = expected_regions.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (left !== want.left) begin
                $error("region_left: expected %0d, actual %0d", want.left, left);
                errors++;
            end
            if (top !== want.top) begin
                $error("region_top: expected %0d, actual %0d", want.top, top);
                errors++;
            end
            if (height !== want.height) begin
                $error("atlas_height: expected %0d, actual %0d", want.height, height);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFGI_W-1:0]      i_cfg_index   = '0;
    logic [HGT_W-1:0]       i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // glyph_id, glyph_width, glyph_height, pad
    logic                   s_axis_tuser  = 1'b0; // vertical
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // region_left, region_top, atlas_height, pad
    logic [1:0]             m_axis_tuser;        // status

    atlas_scoreboard sb;

    int unsigned rx_gap      = 0;
    int unsigned rx_calm     = 0;
    int unsigned rx_hold     = 0;
    int unsigned hold_req    = 0;
    int unsigned hold_seen   = 0;
    int unsigned tx_calm     = 0;
    int unsigned cycle_count = 0;
    bit          idle_on     = 1'b1;

    logic [HGT_W-1:0] base_choices[14] = '{15'd0, 15'd1, 15'd16, 15'd17, 15'd32, 15'd33,
                                          15'd48, 15'd49, 15'd64, 15'd65, 15'd256,
                                          15'd257, 15'd4096, 15'd8191};

    glyph_atlas_shelf_allocator #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .*
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_placement(m_axis_tuser, m_axis_tdata[LEFT_W-1:0],
                                   m_axis_tdata[LEFT_W+TOP_W-1:LEFT_W],
                                   m_axis_tdata[LEFT_W+TOP_W+HGT_W-1:LEFT_W+TOP_W]);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(s_axis_tdata[ID_W-1:0], s_axis_tuser,
                                s_axis_tdata[ID_W+DIM_W-1:ID_W],
                                s_axis_tdata[ID_W+2*DIM_W-1:ID_W+DIM_W]);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
        end
    end

    // result side: short random stalls, calm stretches, one long hold on request
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            rx_hold   = LONG_HOLD;
        end
        if (rx_hold != 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && rx_calm == 0 && $urandom_range(0, 3) == 0) begin
            rx_gap  = $urandom_range(0, 5);
            rx_calm = $urandom_range(0, 40);
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_calm != 0) rx_calm--;
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_cfg(input logic [CFGI_W-1:0] index, input logic [HGT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_glyph(input logic [ID_W-1:0] id, input logic vert,
                              input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        int unsigned gap;
        @(negedge i_clk);
        if (idle_on) begin
            if (tx_calm != 0) begin
                tx_calm--;
            end else if ($urandom_range(0, 2) == 0) begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
                tx_calm = $urandom_range(0, 12);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, h, w, id};
        s_axis_tuser  <= vert;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // wait for the allocator to go idle before touching registers
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_regions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return DIM_W'($urandom_range(0, 48));
        if (r < 90) return DIM_W'($urandom_range(0, 300));
        if (r < 97) return DIM_W'($urandom_range(0, 4095));
        return r[0] ? 12'd4095 : 12'd0;
    endfunction

    task automatic random_request(input t_mix mix);
        int unsigned      roll;
        int unsigned      cnt;
        int unsigned      j;
        int unsigned      tries;
        int unsigned      t_new;
        int unsigned      t_reuse;
        int unsigned      t_resize;
        logic [ID_W-1:0]  id;
        logic             vert;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        roll = $urandom_range(0, 99);
        cnt  = sb.entry_count;
        id   = ID_W'($urandom);
        vert = 1'($urandom_range(0, 1));
        w    = pick_dim();
        h    = pick_dim();
        if (mix == MIX_WIDE) begin
            // always wraps to a new shelf, drives pen_y toward saturation
            w = '1;
            h = DIM_W'($urandom_range(0, 64));
        end else if (cnt != 0) begin
            j = $urandom_range(0, cnt - 1);
            if (mix == MIX_FILL) begin
                t_new    = 15;
                t_reuse  = 70;
                t_resize = 70;
                tries    = 0;
                // look for a glyph stored in one direction only
                while (tries < 8 && sb.find_slot({~sb.slot_key[j][KEY_W-1],
                                                  sb.slot_key[j][ID_W-1:0]}) >= 0) begin
                    j = $urandom_range(0, cnt - 1);
                    tries++;
                end
            end else if (cnt >= 180) begin
                // keep room in the table for the pen saturation run
                t_new    = 4;
                t_reuse  = 8;
                t_resize = 12;
            end else begin
                t_new    = 30;
                t_reuse  = 55;
                t_resize = 65;
            end
            if (roll >= t_new) begin
                id = sb.slot_key[j][ID_W-1:0];
                if (roll < t_reuse) begin
                    vert = ~sb.slot_key[j][KEY_W-1];
                    w    = sb.slot_w[j];
                    h    = sb.slot_h[j];
                end else if (roll < t_resize) begin
                    vert = ~sb.slot_key[j][KEY_W-1];
                end else begin
                    vert = sb.slot_key[j][KEY_W-1];
                end
            end
        end
        send_glyph(id, vert, w, h);
    endtask

    task automatic run_random(input t_mix mix, input int unsigned count);
        repeat (count) random_request(mix);
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // base_size only counts before the first request
        write_cfg(CFG_BASE_SIZE, base_choices[$urandom_range(0, 13)]);
        write_cfg(CFG_PADDING, HGT_W'($urandom_range(1, 3)));
        write_cfg(CFG_MAX_HEIGHT, 15'd4096);

        send_glyph(31'd0, 1'b0, 12'd0, 12'd0);
        send_glyph(31'd0, 1'b0, 12'd7, 12'd9);
        send_glyph(31'd0, 1'b1, 12'd0, 12'd0);
        send_glyph(31'h7FFF_FFFF, 1'b1, 12'd10, 12'd20);
        send_glyph(31'h7FFF_FFFF, 1'b0, 12'd20, 12'd10);
        send_glyph(31'h7FFF_FFFF, 1'b0, 12'd1, 12'd1);
        send_glyph(31'd5, 1'b0, 12'd4095, 12'd12);
        send_glyph(31'd6, 1'b0, 12'd16, 12'd4095);
        send_glyph(31'd6, 1'b0, 12'd16, 12'd4095);
        send_glyph(31'd7, 1'b1, 12'd100, 12'd300);
        send_glyph(31'd8, 1'b0, 12'd4095, 12'd4095);
        send_glyph(31'h4000_0000, 1'b1, 12'hAAA, 12'h555);
        send_glyph(31'h2AAA_AAAA, 1'b0, 12'h555, 12'hAAA);
        send_glyph(31'h5555_5555, 1'b1, 12'h800, 12'h001);
        send_glyph(31'h4000_0000, 1'b0, 12'hAAA, 12'h555);
        send_glyph(31'h5555_5555, 1'b0, 12'h800, 12'h001);
        settle();

        write_cfg(CFG_BASE_SIZE, 15'd0);
        write_cfg(CFG_PADDING, HGT_W'($urandom_range(0, 8)));
        write_cfg(CFG_MAX_HEIGHT, 15'h7FFF);
        run_random(MIX_CAPPED, 100);
        hold_req++;
        run_random(MIX_CAPPED, 350);
        settle();

        write_cfg(CFG_BASE_SIZE, 15'h7FFF);
        write_cfg(CFG_PADDING, 15'd0);
        write_cfg(CFG_MAX_HEIGHT, 15'd256);
        write_cfg(CFG_UNUSED, HGT_W'($urandom_range(0, 15'h7FFF)));
        run_random(MIX_CAPPED, 200);
        settle();

        write_cfg(CFG_PADDING, 15'h7FFF);
        write_cfg(CFG_MAX_HEIGHT, HGT_W'($urandom_range(256, 32767)));
        run_random(MIX_CAPPED, 200);
        settle();

        write_cfg(CFG_PADDING, 15'd255);
        write_cfg(CFG_MAX_HEIGHT, 15'd256);
        run_random(MIX_WIDE, 160);
        settle();

        write_cfg(CFG_BASE_SIZE, 15'd1);
        write_cfg(CFG_PADDING, HGT_W'($urandom_range(0, 255)));
        write_cfg(CFG_MAX_HEIGHT, 15'h7FFF);
        write_cfg(CFG_UNUSED, 15'd0);
        idle_on = 1'b0;
        run_random(MIX_FILL, 424);
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
